// ===== rtl/wrt_pkg.sv =====
`timescale 1ns / 1ps
package wrt_pkg;

    localparam int POSITION_WIDTH_DEF = 24;
    localparam int CORDIC_STEPS_DEF   = 16;
    localparam int ATAN_ENTRIES       = 24;

    localparam int PI_Q12      = 12868;
    localparam int TWO_PI_Q12  = 25736;
    localparam int PI_Q20      = 3294199;
    localparam int SEARCH_TURN = 1229;
    localparam int ROUND_Q12   = 2048;

    typedef logic [1:0] t_phase;
    localparam t_phase PH_TRANSFORM = 2'd0;
    localparam t_phase PH_ROTATE    = 2'd1;
    localparam t_phase PH_TRANSLATE = 2'd2;

    localparam logic [1:0] CODE_WAIT   = 2'd0;
    localparam logic [1:0] KIND_TARGET = 2'd2;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_POS_TOL = 3'd0;
    localparam t_reg_idx REG_ANG_TOL = 3'd1;
    localparam t_reg_idx REG_MIN_VEL = 3'd2;
    localparam t_reg_idx REG_MAX_VEL = 3'd3;
    localparam t_reg_idx REG_ROT_P   = 3'd4;
    localparam t_reg_idx REG_ROT_D   = 3'd5;
    localparam t_reg_idx REG_TRN_P   = 3'd6;
    localparam t_reg_idx REG_TRN_D   = 3'd7;

    typedef struct packed {
        logic [15:0] pos_tol;
        logic [13:0] ang_tol;
        logic [13:0] min_vel;
        logic [13:0] max_vel;
        logic [15:0] rot_p;
        logic [15:0] rot_d;
        logic [15:0] trn_p;
        logic [15:0] trn_d;
    } t_cfg;

    // arctan(2^-i) in units of 2^-20 rad
    function automatic logic [19:0] atan_q20(input logic [4:0] i);
        logic [19:0] v;
        case (i)
            5'd0:  v = 20'd823550;
            5'd1:  v = 20'd486170;
            5'd2:  v = 20'd256879;
            5'd3:  v = 20'd130396;
            5'd4:  v = 20'd65451;
            5'd5:  v = 20'd32757;
            5'd6:  v = 20'd16383;
            5'd7:  v = 20'd8192;
            5'd8:  v = 20'd4096;
            5'd9:  v = 20'd2048;
            5'd10: v = 20'd1024;
            5'd11: v = 20'd512;
            5'd12: v = 20'd256;
            5'd13: v = 20'd128;
            5'd14: v = 20'd64;
            5'd15: v = 20'd32;
            5'd16: v = 20'd16;
            5'd17: v = 20'd8;
            5'd18: v = 20'd4;
            5'd19: v = 20'd2;
            5'd20: v = 20'd1;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/wrt_cfg_regs.sv =====
`timescale 1ns / 1ps
module wrt_cfg_regs
    import wrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_tol <= 16'd410;
            r_cfg.ang_tol <= 14'd205;
            r_cfg.min_vel <= 14'd614;
            r_cfg.max_vel <= 14'd1229;
            r_cfg.rot_p   <= 16'd1229;
            r_cfg.rot_d   <= 16'd41;
            r_cfg.trn_p   <= 16'd6144;
            r_cfg.trn_d   <= 16'd82;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_POS_TOL: r_cfg.pos_tol <= pwdata[15:0];
                REG_ANG_TOL: r_cfg.ang_tol <= pwdata[13:0];
                REG_MIN_VEL: r_cfg.min_vel <= pwdata[13:0];
                REG_MAX_VEL: r_cfg.max_vel <= pwdata[13:0];
                REG_ROT_P:   r_cfg.rot_p   <= pwdata[15:0];
                REG_ROT_D:   r_cfg.rot_d   <= pwdata[15:0];
                REG_TRN_P:   r_cfg.trn_p   <= pwdata[15:0];
                REG_TRN_D:   r_cfg.trn_d   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_POS_TOL: prdata = {16'd0, r_cfg.pos_tol};
            REG_ANG_TOL: prdata = {18'd0, r_cfg.ang_tol};
            REG_MIN_VEL: prdata = {18'd0, r_cfg.min_vel};
            REG_MAX_VEL: prdata = {18'd0, r_cfg.max_vel};
            REG_ROT_P:   prdata = {16'd0, r_cfg.rot_p};
            REG_ROT_D:   prdata = {16'd0, r_cfg.rot_d};
            REG_TRN_P:   prdata = {16'd0, r_cfg.trn_p};
            REG_TRN_D:   prdata = {16'd0, r_cfg.trn_d};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/wrt_sqrt.sv =====
`timescale 1ns / 1ps
module wrt_sqrt
    import wrt_pkg::*;
#(
    parameter int PW = POSITION_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [2*PW+1:0]   i_radicand,
    output logic              o_busy,
    output logic [PW:0]       o_root
);

    localparam int RADW  = 2 * PW + 2;
    localparam int ROOTW = PW + 1;
    localparam int RW    = PW + 4;
    localparam int NIT   = PW + 1;
    localparam int CNTW  = $clog2(NIT);

    logic [RADW-1:0]  r_rad;
    logic [ROOTW-1:0] r_root;
    logic [RW-1:0]    r_rem;
    logic [CNTW-1:0]  r_cnt;
    logic             r_busy;

    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;

    // one result bit per cycle, two radicand bits brought down
    assign rem_sh = {r_rem[RW-3:0], r_rad[RADW-1:RADW-2]};
    assign trial  = RW'({r_root, 2'b01});
    assign o_busy = r_busy;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNTW'(NIT - 1);
            r_rad  <= i_radicand;
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[RADW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOTW-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOTW-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/wrt_cordic.sv =====
`timescale 1ns / 1ps
module wrt_cordic
    import wrt_pkg::*;
#(
    parameter int PW    = POSITION_WIDTH_DEF,
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [PW:0] i_dx,
    input  logic signed [PW:0] i_dy,
    output logic               o_busy,
    output logic signed [16:0] o_bearing
);

    localparam int XW   = PW + 4;
    localparam int ZW   = 25;
    localparam int CNTW = $clog2(STEPS);

    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [CNTW-1:0]      r_i;
    logic                 r_busy;

    logic signed [XW-1:0] dx_e, dy_e, xs, ys;
    logic signed [ZW-1:0] at, z_rnd;

    assign dx_e  = XW'(i_dx);
    assign dy_e  = XW'(i_dy);
    assign xs    = r_x >>> r_i;
    assign ys    = r_y >>> r_i;
    assign at    = ZW'(signed'({1'b0, atan_q20(5'(r_i))}));
    assign z_rnd = r_z + ZW'(128);
    assign o_bearing = z_rnd[ZW-1:8];
    assign o_busy    = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_i <= '0;
            if (i_dx == '0 && i_dy == '0) begin
                // coincident points: bearing stays zero
                r_busy <= 1'b0;
                r_z    <= '0;
                r_x    <= '0;
                r_y    <= '0;
            end else begin
                r_busy <= 1'b1;
                if (i_dx < 0) begin
                    r_x <= -dx_e;
                    r_y <= -dy_e;
                    r_z <= (i_dy >= 0) ? ZW'(PI_Q20) : -ZW'(PI_Q20);
                end else begin
                    r_x <= dx_e;
                    r_y <= dy_e;
                    r_z <= '0;
                end
            end
        end else if (r_busy) begin
            if (r_y >= 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end
            if (r_i == CNTW'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_i <= r_i + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/waypoint_rotate_translate_pd.sv =====
`timescale 1ns / 1ps
// in transform, SQX and SQY square dx and dy on the one multiplier, SUM starts the bit-per-cycle
// square root and the CORDIC alongside it in SOLVE, and WRAP brings the heading error into range;
// rotating or translating adds MULP, MULD and SHAPE; without auto mode or a known nest the result
// follows in the next cycle
// one transaction at a time: input stalled from acceptance until the result is taken
// sync active-low reset: phase back to transform, PD history cleared, default register values
module waypoint_rotate_translate_pd
    import wrt_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [4:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_auto_mode,
    input  logic                             i_collection_point_known,
    input  logic [1:0]                       i_goal_kind,
    input  logic signed [POSITION_WIDTH-1:0] i_current_x,
    input  logic signed [POSITION_WIDTH-1:0] i_current_y,
    input  logic signed [14:0]               i_current_heading,
    input  logic signed [POSITION_WIDTH-1:0] i_goal_x,
    input  logic signed [POSITION_WIDTH-1:0] i_goal_y,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_velocity_valid,
    output logic signed [14:0]               o_linear_velocity,
    output logic signed [14:0]               o_angular_velocity,
    output logic                             o_goal_reached,
    output logic [1:0]                       o_phase_code
);

    localparam int PW  = POSITION_WIDTH;
    localparam int MW  = PW + 2;
    localparam int AW  = 2 * MW + 1;
    localparam int CW  = AW - 12;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_SUM, ST_SOLVE, ST_WRAP,
        ST_MULP, ST_MULD, ST_SHAPE, ST_OUT
    } t_state;

    t_cfg cfg;

    wrt_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    t_state                r_state;
    t_phase                r_phase;
    logic signed [15:0]    r_last_he;
    logic [PW:0]           r_last_dist;
    logic signed [PW:0]    r_dx, r_dy;
    logic signed [14:0]    r_hd;
    logic [1:0]            r_kind;
    logic signed [17:0]    r_err;
    logic signed [AW-1:0]  r_acc;
    logic signed [2*MW-1:0] r_prod;
    logic                  r_vv, r_reached;
    logic signed [14:0]    r_lin, r_ang;
    logic [1:0]            r_code;

    logic                  in_acc, out_acc, start;
    logic                  sqrt_busy, cordic_busy;
    logic [PW:0]           distance;
    logic signed [16:0]    bearing;
    logic [2*PW+1:0]       radicand;
    logic signed [MW-1:0]  mul_a, mul_b;
    logic signed [2*MW-1:0] prod;
    logic signed [16:0]    he_diff;
    logic signed [MW-1:0]  dist_diff;
    logic signed [17:0]    err_init;
    logic [17:0]           aerr;
    logic [PW:0]           pos_tol_e;
    logic signed [AW-1:0]  sh_sum;
    logic signed [CW-1:0]  sh_c, sh_f, sh_o, mn, mx;
    logic [CW-1:0]         sh_mag;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign start       = (r_state == ST_SUM);
    assign radicand    = (2*PW+2)'(r_acc + AW'(r_prod));

    wrt_sqrt #(.PW(PW)) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_radicand (radicand),
        .o_busy     (sqrt_busy),
        .o_root     (distance)
    );

    wrt_cordic #(.PW(PW), .STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_dx      (r_dx),
        .i_dy      (r_dy),
        .o_busy    (cordic_busy),
        .o_bearing (bearing)
    );

    assign he_diff   = 17'(r_last_he) - 17'(r_err);
    assign dist_diff = signed'({1'b0, r_last_dist}) - signed'({1'b0, distance});
    assign err_init  = 18'(bearing) - 18'(r_hd);
    assign aerr      = r_err[17] ? 18'(-r_err) : 18'(r_err);
    assign pos_tol_e = (PW+1)'(cfg.pos_tol);

    // the one multiplier: squares first, then the two PD products
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_SQX: begin
                mul_a = MW'(r_dx);
                mul_b = MW'(r_dx);
            end
            ST_SQY: begin
                mul_a = MW'(r_dy);
                mul_b = MW'(r_dy);
            end
            ST_MULP: begin
                if (r_phase == PH_ROTATE) begin
                    mul_a = MW'(r_err);
                    mul_b = MW'(signed'({1'b0, cfg.rot_p}));
                end else begin
                    mul_a = signed'({1'b0, distance});
                    mul_b = MW'(signed'({1'b0, cfg.trn_p}));
                end
            end
            ST_MULD: begin
                if (r_phase == PH_ROTATE) begin
                    mul_a = MW'(he_diff);
                    mul_b = MW'(signed'({1'b0, cfg.rot_d}));
                end else begin
                    mul_a = dist_diff;
                    mul_b = MW'(signed'({1'b0, cfg.trn_d}));
                end
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    // round, floor to min magnitude, then cap
    always_comb begin
        sh_sum = r_acc + AW'(r_prod) + AW'(ROUND_Q12);
        sh_c   = sh_sum[AW-1:12];
        mn     = CW'(signed'({1'b0, cfg.min_vel}));
        mx     = CW'(signed'({1'b0, cfg.max_vel}));
        sh_mag = sh_c[CW-1] ? CW'(-sh_c) : CW'(sh_c);
        sh_f   = sh_c;
        if (sh_mag < CW'(cfg.min_vel)) begin
            if (sh_c > 0) begin
                sh_f = mn;
            end else if (sh_c < 0) begin
                sh_f = -mn;
            end
        end
        sh_o = sh_f;
        if (sh_f > mx) begin
            sh_o = mx;
        end else if (sh_f < -mx) begin
            sh_o = -mx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_TRANSFORM;
            r_last_he   <= '0;
            r_last_dist <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_dx      <= (PW+1)'(i_goal_x) - (PW+1)'(i_current_x);
                        r_dy      <= (PW+1)'(i_goal_y) - (PW+1)'(i_current_y);
                        r_hd      <= i_current_heading;
                        r_kind    <= i_goal_kind;
                        r_lin     <= '0;
                        r_reached <= 1'b0;
                        if (!i_auto_mode) begin
                            r_vv    <= 1'b0;
                            r_ang   <= '0;
                            r_code  <= CODE_WAIT;
                            r_state <= ST_OUT;
                        end else if (!i_collection_point_known) begin
                            r_vv    <= 1'b1;
                            r_ang   <= 15'(SEARCH_TURN);
                            r_code  <= r_phase + 2'd1;
                            r_state <= ST_OUT;
                        end else begin
                            r_vv    <= 1'b0;
                            r_ang   <= '0;
                            r_code  <= r_phase + 2'd1;
                            r_state <= ST_SQX;
                        end
                    end
                end
                ST_SQX: begin
                    r_acc   <= AW'(prod);
                    r_state <= ST_SQY;
                end
                ST_SQY: begin
                    r_prod  <= prod;
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_state <= ST_SOLVE;
                end
                ST_SOLVE: begin
                    if (!sqrt_busy && !cordic_busy) begin
                        r_err   <= err_init;
                        r_state <= ST_WRAP;
                    end
                end
                ST_WRAP: begin
                    if (r_err >= 18'(PI_Q12)) begin
                        r_err <= r_err - 18'(TWO_PI_Q12);
                    end else if (r_err < -18'(PI_Q12)) begin
                        r_err <= r_err + 18'(TWO_PI_Q12);
                    end else if (r_phase == PH_TRANSFORM) begin
                        if (distance < pos_tol_e) begin
                            r_reached <= 1'b1;
                            r_vv      <= (r_kind == KIND_TARGET);
                        end else if (aerr > 18'(cfg.ang_tol)) begin
                            r_phase <= PH_ROTATE;
                        end else if (distance > pos_tol_e) begin
                            r_phase <= PH_TRANSLATE;
                        end
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_MULP;
                    end
                end
                ST_MULP: begin
                    r_acc   <= AW'(prod);
                    r_state <= ST_MULD;
                end
                ST_MULD: begin
                    r_prod  <= prod;
                    r_state <= ST_SHAPE;
                end
                ST_SHAPE: begin
                    r_vv <= 1'b1;
                    if (r_phase == PH_ROTATE) begin
                        r_ang     <= sh_o[14:0];
                        r_last_he <= r_err[15:0];
                    end else begin
                        r_lin       <= sh_o[14:0];
                        r_last_dist <= distance;
                    end
                    r_phase <= PH_TRANSFORM;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_acc) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_velocity_valid   = r_vv;
    assign o_linear_velocity  = r_lin;
    assign o_angular_velocity = r_ang;
    assign o_goal_reached     = r_reached;
    assign o_phase_code       = r_code;

    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result is pending");

    a_units_only_solving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sqrt_busy || cordic_busy) |-> (r_state == ST_SOLVE))
        else $error("arithmetic unit busy outside solve");

    a_reached_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_goal_reached) |->
            (o_linear_velocity == '0 && o_angular_velocity == '0))
        else $error("motion commanded with goal reached");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |=> !o_out_valid)
        else $error("result repeated");

    a_phase_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHAPE) |=> (r_phase == PH_TRANSFORM))
        else $error("phase not returned to transform");

endmodule
